// ===== src/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Shared constants, token codes and character helpers for the tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int OFFSET_BITS_DEF = 20;
   localparam int POS_BITS_DEF    = 16;
   localparam int MAX_TOKENS      = 4;
   localparam int QUEUE_DEPTH     = 8;

   // token kinds
   localparam logic [5:0] TK_INT      = 6'd0;
   localparam logic [5:0] TK_DEC      = 6'd1;
   localparam logic [5:0] TK_STR      = 6'd2;
   localparam logic [5:0] TK_TRUE     = 6'd3;
   localparam logic [5:0] TK_FALSE    = 6'd4;
   localparam logic [5:0] TK_FN       = 6'd5;
   localparam logic [5:0] TK_LET      = 6'd6;
   localparam logic [5:0] TK_VAR      = 6'd7;
   localparam logic [5:0] TK_STRUCT   = 6'd8;
   localparam logic [5:0] TK_IF       = 6'd9;
   localparam logic [5:0] TK_ELSE     = 6'd10;
   localparam logic [5:0] TK_WHILE    = 6'd11;
   localparam logic [5:0] TK_RETURN   = 6'd12;
   localparam logic [5:0] TK_ALLOC    = 6'd13;
   localparam logic [5:0] TK_FREE     = 6'd14;
   localparam logic [5:0] TK_PTR      = 6'd15;
   localparam logic [5:0] TK_IDENT    = 6'd16;
   localparam logic [5:0] TK_U8       = 6'd17;
   localparam logic [5:0] TK_U16      = 6'd18;
   localparam logic [5:0] TK_U32      = 6'd19;
   localparam logic [5:0] TK_U64      = 6'd20;
   localparam logic [5:0] TK_I8       = 6'd21;
   localparam logic [5:0] TK_I16      = 6'd22;
   localparam logic [5:0] TK_I32      = 6'd23;
   localparam logic [5:0] TK_I64      = 6'd24;
   localparam logic [5:0] TK_F64      = 6'd25;
   localparam logic [5:0] TK_BOOL     = 6'd26;
   localparam logic [5:0] TK_VOID     = 6'd27;
   localparam logic [5:0] TK_PLUS     = 6'd28;
   localparam logic [5:0] TK_MINUS    = 6'd29;
   localparam logic [5:0] TK_STAR     = 6'd30;
   localparam logic [5:0] TK_SLASH    = 6'd31;
   localparam logic [5:0] TK_PERCENT  = 6'd32;
   localparam logic [5:0] TK_EQ       = 6'd33;
   localparam logic [5:0] TK_NEQ      = 6'd34;
   localparam logic [5:0] TK_LT       = 6'd35;
   localparam logic [5:0] TK_GT       = 6'd36;
   localparam logic [5:0] TK_LTE      = 6'd37;
   localparam logic [5:0] TK_GTE      = 6'd38;
   localparam logic [5:0] TK_AND      = 6'd39;
   localparam logic [5:0] TK_OR       = 6'd40;
   localparam logic [5:0] TK_NOT      = 6'd41;
   localparam logic [5:0] TK_ASSIGN   = 6'd42;
   localparam logic [5:0] TK_ARROW    = 6'd43;
   localparam logic [5:0] TK_LPAREN   = 6'd44;
   localparam logic [5:0] TK_RPAREN   = 6'd45;
   localparam logic [5:0] TK_LBRACE   = 6'd46;
   localparam logic [5:0] TK_RBRACE   = 6'd47;
   localparam logic [5:0] TK_LBRACKET = 6'd48;
   localparam logic [5:0] TK_RBRACKET = 6'd49;
   localparam logic [5:0] TK_COMMA    = 6'd50;
   localparam logic [5:0] TK_COLON    = 6'd51;
   localparam logic [5:0] TK_SEMI     = 6'd52;
   localparam logic [5:0] TK_DOT      = 6'd53;
   localparam logic [5:0] TK_AMP      = 6'd54;
   localparam logic [5:0] TK_END      = 6'd55;
   localparam logic [5:0] TK_ERROR    = 6'd56;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_UNEXP    = 2'd1;
   localparam logic [1:0] ERR_LONE_BAR = 2'd2;
   localparam logic [1:0] ERR_OPEN_STR = 2'd3;

   // write group from the front to the queue
   typedef struct packed {
      logic       en;
      logic [2:0] count;
   } push_type;

   function automatic int tok_bits(input int ob, input int pb);
      return 145 + 2 * ob + 2 * pb;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == "_");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (is_digit(c)) v = c - 8'h30;
      else if ((c >= "a") && (c <= "f")) v = c - 8'h57;
      else v = c - 8'h37;
      return v[3:0];
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      unique case (c)
         "(": k = TK_LPAREN;
         ")": k = TK_RPAREN;
         "{": k = TK_LBRACE;
         "}": k = TK_RBRACE;
         "[": k = TK_LBRACKET;
         "]": k = TK_RBRACKET;
         ",": k = TK_COMMA;
         ":": k = TK_COLON;
         ";": k = TK_SEMI;
         ".": k = TK_DOT;
         "+": k = TK_PLUS;
         "*": k = TK_STAR;
         "%": k = TK_PERCENT;
         default: k = TK_ERROR;
      endcase
      return k;
   endfunction

   // keyword lookup on the packed word prefix
   function automatic logic [5:0] kw_kind(input logic [47:0] w);
      logic [5:0] k;
      unique case (w)
         {32'h0, "fn"}:      k = TK_FN;
         {32'h0, "if"}:      k = TK_IF;
         {32'h0, "u8"}:      k = TK_U8;
         {32'h0, "i8"}:      k = TK_I8;
         {24'h0, "let"}:     k = TK_LET;
         {24'h0, "var"}:     k = TK_VAR;
         {24'h0, "ptr"}:     k = TK_PTR;
         {24'h0, "u16"}:     k = TK_U16;
         {24'h0, "u32"}:     k = TK_U32;
         {24'h0, "u64"}:     k = TK_U64;
         {24'h0, "i16"}:     k = TK_I16;
         {24'h0, "i32"}:     k = TK_I32;
         {24'h0, "i64"}:     k = TK_I64;
         {24'h0, "f64"}:     k = TK_F64;
         {16'h0, "else"}:    k = TK_ELSE;
         {16'h0, "bool"}:    k = TK_BOOL;
         {16'h0, "true"}:    k = TK_TRUE;
         {16'h0, "void"}:    k = TK_VOID;
         {16'h0, "free"}:    k = TK_FREE;
         {8'h0, "false"}:    k = TK_FALSE;
         {8'h0, "while"}:    k = TK_WHILE;
         {8'h0, "alloc"}:    k = TK_ALLOC;
         "struct":           k = TK_STRUCT;
         "return":           k = TK_RETURN;
         default:            k = TK_IDENT;
      endcase
      return k;
   endfunction

   // two-character operators, indexed from the equals-pending mode
   function automatic logic [7:0] op_second(input logic [2:0] i);
      logic [7:0] c;
      unique case (i)
         3'd4:    c = "&";
         3'd5:    c = ">";
         3'd6:    c = "|";
         default: c = "=";
      endcase
      return c;
   endfunction

   function automatic logic [5:0] op_two(input logic [2:0] i);
      logic [5:0] k;
      unique case (i)
         3'd0:    k = TK_EQ;
         3'd1:    k = TK_NEQ;
         3'd2:    k = TK_LTE;
         3'd3:    k = TK_GTE;
         3'd4:    k = TK_AND;
         3'd5:    k = TK_ARROW;
         default: k = TK_OR;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] op_one(input logic [2:0] i);
      logic [5:0] k;
      unique case (i)
         3'd0:    k = TK_ASSIGN;
         3'd1:    k = TK_NOT;
         3'd2:    k = TK_LT;
         3'd3:    k = TK_GT;
         3'd4:    k = TK_AMP;
         3'd5:    k = TK_MINUS;
         default: k = TK_ERROR;
      endcase
      return k;
   endfunction

endpackage

// ===== src/sct_front.sv =====
// ----------------------------------------------------------------------------
// sct_front
// Scanner: takes one source byte per accepted cycle, forms up to four tokens.
// ----------------------------------------------------------------------------
module sct_front #(
   parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
   parameter int POS_BITS    = sct_pkg::POS_BITS_DEF,
   localparam int TW         = sct_pkg::tok_bits(OFFSET_BITS, POS_BITS)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [7:0]                             src_byte,
   input  logic                                   is_last,
   output sct_pkg::push_type                      push,
   output logic [sct_pkg::MAX_TOKENS-1:0][TW-1:0] toks
);

   localparam logic [4:0] M_IDLE    = 5'd0;
   localparam logic [4:0] M_IDENT   = 5'd1;
   localparam logic [4:0] M_ZERO    = 5'd2;
   localparam logic [4:0] M_DEC     = 5'd3;
   localparam logic [4:0] M_HEX     = 5'd4;
   localparam logic [4:0] M_DOTP    = 5'd5;
   localparam logic [4:0] M_FRAC    = 5'd6;
   localparam logic [4:0] M_STR     = 5'd7;
   localparam logic [4:0] M_STRESC  = 5'd8;
   localparam logic [4:0] M_LINECMT = 5'd9;
   localparam logic [4:0] M_BLKCMT  = 5'd10;
   localparam logic [4:0] M_BLKSTAR = 5'd11;
   localparam logic [4:0] M_SLASH   = 5'd12;
   localparam logic [4:0] M_EQP     = 5'd13;
   localparam logic [4:0] M_BANGP   = 5'd14;
   localparam logic [4:0] M_LTP     = 5'd15;
   localparam logic [4:0] M_GTP     = 5'd16;
   localparam logic [4:0] M_AMPP    = 5'd17;
   localparam logic [4:0] M_MINUSP  = 5'd18;
   localparam logic [4:0] M_BARP    = 5'd19;

   typedef struct packed {
      logic [4:0]             m;
      logic [OFFSET_BITS-1:0] off;
      logic [OFFSET_BITS-1:0] ts;
      logic [POS_BITS-1:0]    cl;
      logic [POS_BITS-1:0]    cc;
      logic [POS_BITS-1:0]    tl;
      logic [POS_BITS-1:0]    tc;
      logic [63:0]            ia;
      logic [63:0]            fa;
      logic [7:0]             fc;
      logic [47:0]            wp;
      logic                   ended;
   } st_type;

   typedef struct packed {
      logic [5:0]             kind;
      logic [1:0]             err;
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] len;
      logic [POS_BITS-1:0]    line;
      logic [POS_BITS-1:0]    col;
      logic [63:0]            iv;
      logic [63:0]            fd;
      logic [7:0]             fc;
      logic                   eor;
   } tok_type;

   typedef tok_type [sct_pkg::MAX_TOKENS-1:0] tlist_type;

   st_type    st_ff, st_in;
   tlist_type t_c;
   logic [2:0] n_c;

   function automatic void move_over(inout st_type s, input logic [7:0] c);
      if (s.off != '1) s.off = s.off + OFFSET_BITS'(1);
      if (c == 8'h0a) begin
         if (s.cl != '1) s.cl = s.cl + POS_BITS'(1);
         s.cc = POS_BITS'(1);
      end else begin
         if (s.cc != '1) s.cc = s.cc + POS_BITS'(1);
      end
   endfunction

   function automatic void mark(inout st_type s);
      s.ts = s.off;
      s.tl = s.cl;
      s.tc = s.cc;
   endfunction

   function automatic void push_tok(inout tlist_type t, inout logic [2:0] n,
                                    input st_type s, input logic [5:0] kind,
                                    input logic [63:0] iv, input logic [63:0] fd,
                                    input logic [7:0] fc);
      tok_type k;
      k.kind  = kind;
      k.err   = sct_pkg::ERR_NONE;
      k.start = s.ts;
      k.len   = s.off - s.ts;
      k.line  = s.tl;
      k.col   = s.tc;
      k.iv    = iv;
      k.fd    = fd;
      k.fc    = fc;
      k.eor   = 1'b0;
      t[n[1:0]] = k;
      n = n + 3'd1;
   endfunction

   // errors and the end token sit just after the last byte consumed
   function automatic void push_at(inout tlist_type t, inout logic [2:0] n,
                                   input st_type s, input logic [5:0] kind,
                                   input logic [1:0] code);
      tok_type k;
      k       = '0;
      k.kind  = kind;
      k.err   = code;
      k.start = s.off;
      k.line  = s.cl;
      k.col   = s.cc;
      t[n[1:0]] = k;
      n = n + 3'd1;
   endfunction

   function automatic void idle_byte(inout st_type s, inout tlist_type t,
                                     inout logic [2:0] n, input logic [7:0] c);
      logic [5:0] k;
      k = sct_pkg::single_kind(c);
      s.m = M_IDLE;
      if ((c == " ") || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a)) begin
         move_over(s, c);
      end else if (sct_pkg::is_alpha(c) || (c == "_")) begin
         mark(s);
         s.wp = {40'h0, c};
         move_over(s, c);
         s.m = M_IDENT;
      end else if (sct_pkg::is_digit(c)) begin
         mark(s);
         s.ia = {60'h0, c[3:0]};
         s.fa = '0;
         s.fc = '0;
         move_over(s, c);
         s.m = (c == "0") ? M_ZERO : M_DEC;
      end else if (c == 8'h22) begin
         move_over(s, c);
         mark(s);
         s.m = M_STR;
      end else if (k != sct_pkg::TK_ERROR) begin
         mark(s);
         move_over(s, c);
         push_tok(t, n, s, k, '0, '0, '0);
      end else begin
         mark(s);
         move_over(s, c);
         unique case (c)
            "/":     s.m = M_SLASH;
            "=":     s.m = M_EQP;
            "!":     s.m = M_BANGP;
            "<":     s.m = M_LTP;
            ">":     s.m = M_GTP;
            "&":     s.m = M_AMPP;
            "-":     s.m = M_MINUSP;
            "|":     s.m = M_BARP;
            default: push_at(t, n, s, sct_pkg::TK_ERROR, sct_pkg::ERR_UNEXP);
         endcase
      end
   endfunction

   function automatic void emit_pending(inout st_type s, inout tlist_type t,
                                        inout logic [2:0] n);
      logic [4:0] m;
      m   = s.m;
      s.m = M_IDLE;
      unique case (m)
         M_IDENT:
            push_tok(t, n, s, sct_pkg::kw_kind(s.wp), '0, '0, '0);
         M_ZERO, M_DEC, M_HEX:
            push_tok(t, n, s, sct_pkg::TK_INT, s.ia, '0, '0);
         M_DOTP: begin
            // held dot becomes a token of its own
            push_tok(t, n, s, sct_pkg::TK_INT, s.ia, '0, '0);
            mark(s);
            move_over(s, ".");
            push_tok(t, n, s, sct_pkg::TK_DOT, '0, '0, '0);
         end
         M_FRAC:
            push_tok(t, n, s, sct_pkg::TK_DEC, s.ia, s.fa, s.fc);
         M_STR, M_STRESC:
            push_at(t, n, s, sct_pkg::TK_ERROR, sct_pkg::ERR_OPEN_STR);
         M_SLASH:
            push_tok(t, n, s, sct_pkg::TK_SLASH, '0, '0, '0);
         M_BARP:
            push_at(t, n, s, sct_pkg::TK_ERROR, sct_pkg::ERR_LONE_BAR);
         M_EQP, M_BANGP, M_LTP, M_GTP, M_AMPP, M_MINUSP:
            push_tok(t, n, s, sct_pkg::op_one(3'(m - M_EQP)), '0, '0, '0);
         default: ;
      endcase
   endfunction

   function automatic void add_frac(inout st_type s, input logic [7:0] c);
      s.fa = (s.fa << 3) + (s.fa << 1) + {60'h0, c[3:0]};
      if (s.fc != 8'hff) s.fc = s.fc + 8'd1;
      move_over(s, c);
   endfunction

   function automatic void step_byte(inout st_type s, inout tlist_type t,
                                     inout logic [2:0] n, input logic [7:0] c);
      logic fall;
      fall = 1'b1;
      unique case (s.m)
         M_IDLE: begin
            idle_byte(s, t, n, c);
            fall = 1'b0;
         end
         M_IDENT:
            if (sct_pkg::is_word(c)) begin
               if (s.wp[47:40] != 8'h0) s.wp = '1;
               else s.wp = {s.wp[39:0], c};
               move_over(s, c);
               fall = 1'b0;
            end
         M_ZERO, M_DEC:
            if ((s.m == M_ZERO) && ((c == "x") || (c == "X"))) begin
               move_over(s, c);
               s.m  = M_HEX;
               fall = 1'b0;
            end else if (sct_pkg::is_digit(c)) begin
               s.ia = (s.ia << 3) + (s.ia << 1) + {60'h0, c[3:0]};
               move_over(s, c);
               s.m  = M_DEC;
               fall = 1'b0;
            end else if (c == ".") begin
               s.m  = M_DOTP;
               fall = 1'b0;
            end
         M_HEX:
            if (sct_pkg::is_hex(c)) begin
               s.ia = {s.ia[59:0], sct_pkg::hex_val(c)};
               move_over(s, c);
               fall = 1'b0;
            end
         M_DOTP, M_FRAC:
            if (sct_pkg::is_digit(c)) begin
               if (s.m == M_DOTP) move_over(s, ".");
               s.m = M_FRAC;
               add_frac(s, c);
               fall = 1'b0;
            end
         M_STR: begin
            if (c == 8'h22) begin
               push_tok(t, n, s, sct_pkg::TK_STR, '0, '0, '0);
               s.m = M_IDLE;
            end else if (c == 8'h5c) begin
               s.m = M_STRESC;
            end
            move_over(s, c);
            fall = 1'b0;
         end
         M_STRESC: begin
            move_over(s, c);
            s.m  = M_STR;
            fall = 1'b0;
         end
         M_LINECMT: begin
            move_over(s, c);
            if (c == 8'h0a) s.m = M_IDLE;
            fall = 1'b0;
         end
         M_BLKCMT: begin
            move_over(s, c);
            if (c == "*") s.m = M_BLKSTAR;
            fall = 1'b0;
         end
         M_BLKSTAR: begin
            move_over(s, c);
            if (c == "/") s.m = M_IDLE;
            else if (c != "*") s.m = M_BLKCMT;
            fall = 1'b0;
         end
         M_SLASH:
            if (c == "/") begin
               move_over(s, c);
               s.m  = M_LINECMT;
               fall = 1'b0;
            end else if (c == "*") begin
               move_over(s, c);
               s.m  = M_BLKCMT;
               fall = 1'b0;
            end
         M_EQP, M_BANGP, M_LTP, M_GTP, M_AMPP, M_MINUSP, M_BARP:
            if (c == sct_pkg::op_second(3'(s.m - M_EQP))) begin
               move_over(s, c);
               push_tok(t, n, s, sct_pkg::op_two(3'(s.m - M_EQP)), '0, '0, '0);
               s.m  = M_IDLE;
               fall = 1'b0;
            end
         default: ;
      endcase
      if (fall) begin
         emit_pending(s, t, n);
         idle_byte(s, t, n, c);
      end
   endfunction

   function automatic void end_text(inout st_type s, inout tlist_type t,
                                    inout logic [2:0] n);
      emit_pending(s, t, n);
      push_at(t, n, s, sct_pkg::TK_END, sct_pkg::ERR_NONE);
      s.m     = M_IDLE;
      s.ended = 1'b1;
   endfunction

   always_comb begin
      st_type    s;
      tlist_type t;
      logic [2:0] n;
      s = st_ff;
      t = '0;
      n = 3'd0;
      if (accept && !s.ended) begin
         if (src_byte == 8'h0) begin
            end_text(s, t, n);
         end else begin
            step_byte(s, t, n, src_byte);
            if (is_last) end_text(s, t, n);
         end
      end
      for (int i = 0; i < sct_pkg::MAX_TOKENS; i++) begin
         t[i].eor = (3'(i) == (n - 3'd1));
      end
      st_in = s;
      t_c   = t;
      n_c   = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{m: M_IDLE, cl: POS_BITS'(1), cc: POS_BITS'(1),
                    tl: POS_BITS'(1), tc: POS_BITS'(1), default: '0};
      end else begin
         st_ff <= st_in;
      end
   end

   assign push.en    = (n_c != 3'd0);
   assign push.count = n_c;

   always_comb begin
      for (int i = 0; i < sct_pkg::MAX_TOKENS; i++) begin
         toks[i] = t_c[i];
      end
   end

endmodule

// ===== src/sct_queue.sv =====
// ----------------------------------------------------------------------------
// sct_queue
// Token queue: takes a token group per cycle, gives one per unstalled cycle.
// ----------------------------------------------------------------------------
module sct_queue #(
   parameter int TW = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sct_pkg::push_type                      push,
   input  logic [sct_pkg::MAX_TOKENS-1:0][TW-1:0] toks,
   output logic                                   room,
   output logic                                   out_valid,
   input  logic                                   out_stall,
   output logic [TW-1:0]                          out_tok
);

   localparam int DEPTH = sct_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   logic [TW-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          pop;

   assign out_valid = (cnt_ff != '0);
   assign out_tok   = mem_ff[rd_ff];
   assign pop       = out_valid && !out_stall;
   // a whole group always fits when room is high
   assign room      = (cnt_ff <= (PW+1)'(DEPTH - sct_pkg::MAX_TOKENS));

   always_comb begin
      wr_in  = wr_ff + PW'(push.count);
      rd_in  = rd_ff + PW'(pop);
      cnt_in = cnt_ff + (PW+1)'(push.count) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sct_pkg::MAX_TOKENS; i++) begin
         if (push.en && (3'(i) < push.count)) mem_ff[wr_ff + PW'(i)] <= toks[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/source_code_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// source_code_tokenizer_core
// Streaming source tokenizer: bytes in, tokens out.
// ----------------------------------------------------------------------------
// Request channel (req_*): one source byte per accepted request, with
// req_is_last marking the final byte. A zero byte also ends the text.
// Response channel (rsp_*): one token per accepted response; rsp_end_of_run
// flags the last token caused by a given request.
// The scanner takes one byte per cycle while req_stall is low and forms up
// to four tokens from it in that cycle; the tokens are registered into an
// eight-entry queue, and the head of the queue drives rsp_* directly.
// Unless rsp_stall is high, the response side drains one token per cycle,
// so bytes averaging one token or fewer sustain one byte per cycle.
// req_stall rises while the queue has fewer than four free entries.
// When the receiver stalls, the head token holds steady and the queue fills.
// Reset empties the queue and returns the scanner to line 1, column 1,
// offset 0; after the end of text, further bytes are taken and dropped.
// ----------------------------------------------------------------------------
module source_code_tokenizer_core #(
   parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
   parameter int POS_BITS    = sct_pkg::POS_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_src_byte,
   input  logic                   req_is_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [5:0]             rsp_token_kind,
   output logic [1:0]             rsp_error_code,
   output logic [OFFSET_BITS-1:0] rsp_start_offset,
   output logic [OFFSET_BITS-1:0] rsp_text_length,
   output logic [POS_BITS-1:0]    rsp_line_number,
   output logic [POS_BITS-1:0]    rsp_column_number,
   output logic [63:0]            rsp_int_value,
   output logic [63:0]            rsp_frac_digits,
   output logic [7:0]             rsp_frac_count,
   output logic                   rsp_end_of_run
);

   localparam int TW = sct_pkg::tok_bits(OFFSET_BITS, POS_BITS);

   typedef struct packed {
      logic [5:0]             kind;
      logic [1:0]             err;
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] len;
      logic [POS_BITS-1:0]    line;
      logic [POS_BITS-1:0]    col;
      logic [63:0]            iv;
      logic [63:0]            fd;
      logic [7:0]             fc;
      logic                   eor;
   } tok_type;

   sct_pkg::push_type                      push;
   logic [sct_pkg::MAX_TOKENS-1:0][TW-1:0] toks;
   logic                                   room;
   logic                                   accept;
   logic [TW-1:0]                          head;
   tok_type                                head_tok;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   sct_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .POS_BITS    (POS_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .src_byte (req_src_byte),
      .is_last  (req_is_last),
      .push     (push),
      .toks     (toks)
   );

   sct_queue #(
      .TW (TW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .toks      (toks),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_tok   (head)
   );

   assign head_tok          = head;
   assign rsp_token_kind    = head_tok.kind;
   assign rsp_error_code    = head_tok.err;
   assign rsp_start_offset  = head_tok.start;
   assign rsp_text_length   = head_tok.len;
   assign rsp_line_number   = head_tok.line;
   assign rsp_column_number = head_tok.col;
   assign rsp_int_value     = head_tok.iv;
   assign rsp_frac_digits   = head_tok.fd;
   assign rsp_frac_count    = head_tok.fc;
   assign rsp_end_of_run    = head_tok.eor;

endmodule

// ===== tb/source_code_tokenizer_core_tb.sv =====
// ----------------------------------------------------------------------------
// source_code_tokenizer_core_tb
// Feeds one source text through the tokenizer, a few directed bytes and then
// random token-shaped text, and checks every token against a scanner model
// kept in the bench. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module source_code_tokenizer_core_tb;

   localparam int CYCLE_LIMIT = 600000;

   // scanner modes
   typedef enum int {
      M_IDLE, M_IDENT, M_ZERO, M_DEC, M_HEX, M_DOTP, M_FRAC, M_STR, M_STRESC,
      M_LINECMT, M_BLKCMT, M_BLKSTAR, M_SLASH, M_EQP, M_BANGP, M_LTP, M_GTP,
      M_AMPP, M_MINUSP, M_BARP
   } scan_mode_type;

   typedef struct {
      logic [5:0]  kind;
      logic [1:0]  err;
      logic [19:0] start;
      logic [19:0] len;
      logic [15:0] line;
      logic [15:0] col;
      logic [63:0] ival;
      logic [63:0] fdig;
      logic [7:0]  fcnt;
      logic        eor;
   } token_type;

   typedef struct {
      logic [7:0] b;
      logic       last;
      logic       drain;
   } src_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_src_byte = 8'd0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [1:0]  rsp_error_code;
   logic [19:0] rsp_start_offset;
   logic [19:0] rsp_text_length;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic [63:0] rsp_int_value;
   logic [63:0] rsp_frac_digits;
   logic [7:0]  rsp_frac_count;
   logic        rsp_end_of_run;

   source_code_tokenizer_core u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   src_req_type pending_bytes[$];
   token_type   expected_tokens[$];
   token_type   byte_tokens[$];
   int          error_count = 0;
   int          cycle_count = 0;

   // scanner model state
   scan_mode_type mode;
   logic [7:0]  held;
   logic [47:0] word;
   logic [19:0] offset, tok_start;
   logic [15:0] line, col, tok_line, tok_col;
   logic [63:0] ival, fdig;
   logic [7:0]  fcnt;
   logic        ended;

   string      kw_text[24] = '{"fn", "if", "u8", "i8", "let", "var", "ptr", "u16",
      "u32", "u64", "i16", "i32", "i64", "f64", "else", "bool", "true", "void",
      "free", "false", "while", "alloc", "struct", "return"};
   logic [5:0] kw_code[24] = '{sct_pkg::TK_FN, sct_pkg::TK_IF, sct_pkg::TK_U8,
      sct_pkg::TK_I8, sct_pkg::TK_LET, sct_pkg::TK_VAR, sct_pkg::TK_PTR,
      sct_pkg::TK_U16, sct_pkg::TK_U32, sct_pkg::TK_U64, sct_pkg::TK_I16,
      sct_pkg::TK_I32, sct_pkg::TK_I64, sct_pkg::TK_F64, sct_pkg::TK_ELSE,
      sct_pkg::TK_BOOL, sct_pkg::TK_TRUE, sct_pkg::TK_VOID, sct_pkg::TK_FREE,
      sct_pkg::TK_FALSE, sct_pkg::TK_WHILE, sct_pkg::TK_ALLOC, sct_pkg::TK_STRUCT,
      sct_pkg::TK_RETURN};
   logic [7:0] pair_second[7] = '{"=", "=", "=", "=", "&", ">", "|"};
   logic [5:0] pair_kind[7]   = '{sct_pkg::TK_EQ, sct_pkg::TK_NEQ, sct_pkg::TK_LTE,
      sct_pkg::TK_GTE, sct_pkg::TK_AND, sct_pkg::TK_ARROW, sct_pkg::TK_OR};
   logic [5:0] lone_kind[7]   = '{sct_pkg::TK_ASSIGN, sct_pkg::TK_NOT, sct_pkg::TK_LT,
      sct_pkg::TK_GT, sct_pkg::TK_AMP, sct_pkg::TK_MINUS, sct_pkg::TK_ERROR};

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (digit(c)) return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic logic [5:0] punct_kind(logic [7:0] c);
      case (c)
         "(": return sct_pkg::TK_LPAREN;
         ")": return sct_pkg::TK_RPAREN;
         "{": return sct_pkg::TK_LBRACE;
         "}": return sct_pkg::TK_RBRACE;
         "[": return sct_pkg::TK_LBRACKET;
         "]": return sct_pkg::TK_RBRACKET;
         ",": return sct_pkg::TK_COMMA;
         ":": return sct_pkg::TK_COLON;
         ";": return sct_pkg::TK_SEMI;
         ".": return sct_pkg::TK_DOT;
         "+": return sct_pkg::TK_PLUS;
         "*": return sct_pkg::TK_STAR;
         "%": return sct_pkg::TK_PERCENT;
         default: return sct_pkg::TK_ERROR;
      endcase
   endfunction

   function automatic void add_token(logic [5:0] k, logic [1:0] e, logic [19:0] s,
                                     logic [19:0] n, logic [15:0] ln, logic [15:0] cl,
                                     logic [63:0] iv, logic [63:0] fd, logic [7:0] fc);
      token_type t;
      if (byte_tokens.size() >= sct_pkg::MAX_TOKENS) return;
      t = '{k, e, s, n, ln, cl, iv, fd, fc, 1'b0};
      byte_tokens.push_back(t);
   endfunction

   function automatic void token_here(logic [5:0] k, logic [63:0] iv, logic [63:0] fd,
                                      logic [7:0] fc);
      add_token(k, sct_pkg::ERR_NONE, tok_start, offset - tok_start, tok_line, tok_col,
                iv, fd, fc);
   endfunction

   function automatic void error_here(logic [1:0] e);
      add_token(sct_pkg::TK_ERROR, e, offset, '0, line, col, '0, '0, '0);
   endfunction

   function automatic void advance(logic [7:0] c);
      if (offset != '1) offset++;
      if (c == "\n") begin
         if (line != '1) line++;
         col = 16'd1;
      end else if (col != '1) begin
         col++;
      end
   endfunction

   function automatic void mark_start();
      tok_start = offset;
      tok_line  = line;
      tok_col   = col;
   endfunction

   function automatic void start_token(logic [7:0] c);
      logic [5:0] k;
      mode = M_IDLE;
      if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
         advance(c);
         return;
      end
      if (letter(c) || c == "_") begin
         mark_start();
         word = {40'd0, c};
         advance(c);
         mode = M_IDENT;
         return;
      end
      if (digit(c)) begin
         mark_start();
         ival = 64'(c - "0");
         fdig = '0;
         fcnt = '0;
         advance(c);
         mode = (c == "0") ? M_ZERO : M_DEC;
         return;
      end
      if (c == "\"") begin
         advance(c);
         mark_start();
         mode = M_STR;
         return;
      end
      k = punct_kind(c);
      mark_start();
      advance(c);
      if (k != sct_pkg::TK_ERROR) begin
         token_here(k, '0, '0, '0);
         return;
      end
      case (c)
         "/": mode = M_SLASH;
         "=": mode = M_EQP;
         "!": mode = M_BANGP;
         "<": mode = M_LTP;
         ">": mode = M_GTP;
         "&": mode = M_AMPP;
         "-": mode = M_MINUSP;
         "|": mode = M_BARP;
         default: error_here(sct_pkg::ERR_UNEXP);
      endcase
   endfunction

   function automatic void flush_token();
      scan_mode_type m;
      logic [5:0] k;
      logic [47:0] w;
      m = mode;
      mode = M_IDLE;
      case (m)
         M_IDENT: begin
            k = sct_pkg::TK_IDENT;
            foreach (kw_text[i]) begin
               w = '0;
               for (int j = 0; j < kw_text[i].len(); j++) w = {w[39:0], kw_text[i][j]};
               if (w == word) k = kw_code[i];
            end
            token_here(k, '0, '0, '0);
         end
         M_ZERO, M_DEC, M_HEX: token_here(sct_pkg::TK_INT, ival, '0, '0);
         M_DOTP: begin
            token_here(sct_pkg::TK_INT, ival, '0, '0);
            start_token(held);
         end
         M_FRAC:           token_here(sct_pkg::TK_DEC, ival, fdig, fcnt);
         M_STR, M_STRESC:  error_here(sct_pkg::ERR_OPEN_STR);
         M_SLASH:          token_here(sct_pkg::TK_SLASH, '0, '0, '0);
         M_BARP:           error_here(sct_pkg::ERR_LONE_BAR);
         M_EQP, M_BANGP, M_LTP, M_GTP, M_AMPP, M_MINUSP:
            token_here(lone_kind[m - M_EQP], '0, '0, '0);
         default: ;
      endcase
   endfunction

   function automatic void take_frac(logic [7:0] c);
      fdig = fdig * 64'd10 + 64'(c - "0");
      if (fcnt != 8'd255) fcnt++;
      advance(c);
   endfunction

   function automatic void scan_byte(logic [7:0] c);
      case (mode)
         M_IDLE: begin
            start_token(c);
            return;
         end
         M_IDENT: if (letter(c) || digit(c) || c == "_") begin
            word = (word[47:40] != 0) ? 48'hFFFF_FFFF_FFFF : {word[39:0], c};
            advance(c);
            return;
         end
         M_ZERO, M_DEC: begin
            if (mode == M_ZERO && (c == "x" || c == "X")) begin
               advance(c);
               mode = M_HEX;
               return;
            end
            if (digit(c)) begin
               ival = ival * 64'd10 + 64'(c - "0");
               advance(c);
               mode = M_DEC;
               return;
            end
            if (c == ".") begin
               held = c;
               mode = M_DOTP;
               return;
            end
         end
         M_HEX: if (hex_digit(c) >= 0) begin
            ival = ival * 64'd16 + 64'(hex_digit(c));
            advance(c);
            return;
         end
         M_DOTP: if (digit(c)) begin
            advance(held);
            mode = M_FRAC;
            take_frac(c);
            return;
         end
         M_FRAC: if (digit(c)) begin
            take_frac(c);
            return;
         end
         M_STR: begin
            if (c == "\"") begin
               token_here(sct_pkg::TK_STR, '0, '0, '0);
               advance(c);
               mode = M_IDLE;
               return;
            end
            if (c == "\\") mode = M_STRESC;
            advance(c);
            return;
         end
         M_STRESC: begin
            advance(c);
            mode = M_STR;
            return;
         end
         M_LINECMT: begin
            advance(c);
            if (c == "\n") mode = M_IDLE;
            return;
         end
         M_BLKCMT: begin
            advance(c);
            if (c == "*") mode = M_BLKSTAR;
            return;
         end
         M_BLKSTAR: begin
            advance(c);
            if (c == "/") mode = M_IDLE;
            else if (c != "*") mode = M_BLKCMT;
            return;
         end
         M_SLASH: if (c == "/" || c == "*") begin
            advance(c);
            mode = (c == "/") ? M_LINECMT : M_BLKCMT;
            return;
         end
         default: if (c == pair_second[mode - M_EQP]) begin
            advance(c);
            token_here(pair_kind[mode - M_EQP], '0, '0, '0);
            mode = M_IDLE;
            return;
         end
      endcase
      flush_token();
      start_token(c);
   endfunction

   function automatic void close_text();
      flush_token();
      add_token(sct_pkg::TK_END, sct_pkg::ERR_NONE, offset, '0, line, col, '0, '0, '0);
      mode  = M_IDLE;
      ended = 1'b1;
   endfunction

   function automatic void tokenize_byte(logic [7:0] c, logic last);
      byte_tokens.delete();
      if (ended) return;
      if (c == 0) begin
         close_text();
      end else begin
         scan_byte(c);
         if (last) close_text();
      end
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].eor = 1'b1;
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic void add_byte(logic [7:0] b, logic last = 0, logic drain = 0);
      src_req_type r;
      r = '{b, last, drain};
      pending_bytes.push_back(r);
   endfunction

   function automatic void add_text(string s);
      foreach (s[i]) add_byte(s[i]);
   endfunction

   function automatic void add_digits(int n, bit hex);
      string hx = "0123456789abcdefABCDEF";
      for (int i = 0; i < n; i++)
         add_byte(hex ? hx[$urandom_range(0, 21)] : 8'("0" + $urandom_range(0, 9)));
   endfunction

   function automatic void add_word();
      string wc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      int n;
      if ($urandom_range(0, 1)) begin
         add_text(kw_text[$urandom_range(0, 23)]);
         if ($urandom_range(0, 3) == 0) add_byte(wc[$urandom_range(0, 62)]);
         return;
      end
      add_byte(wc[$urandom_range(0, 52)]);
      n = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) add_byte(wc[$urandom_range(0, 62)]);
   endfunction

   function automatic void add_piece();
      string ops = "+-*/%=!<>&|(){}[],:;.#@$?~`^'";
      string ws  = " \t\r\n";
      int n;
      case ($urandom_range(0, 11))
         0, 1: add_word();
         2: add_digits($urandom_range(1, 22), 0);
         3: begin
            add_text($urandom_range(0, 1) ? "0x" : "0X");
            add_digits($urandom_range(0, 18), 1);
         end
         4: begin
            add_digits($urandom_range(1, 4), 0);
            add_byte(".");
            if ($urandom_range(0, 3)) add_digits($urandom_range(1, 22), 0);
         end
         5: begin
            add_byte("\"");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
               add_byte($urandom_range(0, 3) == 0 ? "\\" : 8'($urandom_range(1, 255)));
            add_byte("\"");
         end
         6: begin
            add_text("//");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) add_byte(8'($urandom_range(1, 255)));
            add_byte("\n");
         end
         7: begin
            add_text("/*");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
               add_byte($urandom_range(0, 2) == 0 ? "*" : 8'($urandom_range(1, 255)));
            add_text("*/");
         end
         8, 9: begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) add_byte(ops[$urandom_range(0, 28)]);
         end
         10: add_byte(8'($urandom_range(1, 255)));
         default: add_byte(ws[$urandom_range(0, 3)]);
      endcase
      if ($urandom_range(0, 2)) add_byte(ws[$urandom_range(0, 3)]);
   endfunction

   // ------------------------------------------------------------------ driver
   int  gap_left = 0;
   int  bytes_sent = 0;
   bit  steady_send = 0;
   bit  all_sent = 0;

   always @(posedge clock) begin
      src_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            tokenize_byte(req_src_byte, req_is_last);
            bytes_sent++;
            if (bytes_sent % 64 == 0) steady_send = !steady_send;
         end
         if (req_valid && req_stall) begin
            // payload holds
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0 &&
                      !(pending_bytes[0].drain && expected_tokens.size() > 0)) begin
            r = pending_bytes.pop_front();
            req_valid    <= 1'b1;
            req_src_byte <= r.b;
            req_is_last  <= r.last;
            gap_left = steady_send ? 0 : int'($urandom_range(0, 16));
         end else begin
            req_valid <= 1'b0;
            all_sent = pending_bytes.size() == 0;
         end
      end
   end

   // ----------------------------------------------------------------- monitor
   int tokens_seen = 0;
   int hold_left = 0;
   bit held_off = 0;

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at token %0d", what, got, want,
               tokens_seen);
      error_count++;
   endtask

   always @(posedge clock) begin
      token_type t;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               report("unexpected token kind", 64'(rsp_token_kind), '0);
            end else begin
               t = expected_tokens.pop_front();
               if (rsp_token_kind !== t.kind)
                  report("kind", 64'(rsp_token_kind), 64'(t.kind));
               if (rsp_error_code !== t.err)
                  report("error", 64'(rsp_error_code), 64'(t.err));
               if (rsp_start_offset !== t.start)
                  report("offset", 64'(rsp_start_offset), 64'(t.start));
               if (rsp_text_length !== t.len)
                  report("length", 64'(rsp_text_length), 64'(t.len));
               if (rsp_line_number !== t.line)
                  report("line", 64'(rsp_line_number), 64'(t.line));
               if (rsp_column_number !== t.col)
                  report("column", 64'(rsp_column_number), 64'(t.col));
               if (rsp_int_value !== t.ival)
                  report("int", rsp_int_value, t.ival);
               if (rsp_frac_digits !== t.fdig)
                  report("frac", rsp_frac_digits, t.fdig);
               if (rsp_frac_count !== t.fcnt)
                  report("frac count", 64'(rsp_frac_count), 64'(t.fcnt));
               if (rsp_end_of_run !== t.eor)
                  report("end of run", 64'(rsp_end_of_run), 64'(t.eor));
            end
            tokens_seen++;
            // one long hold-off so the queue fills and the input stalls
            if (tokens_seen == 8 && !held_off) begin
               held_off = 1;
               hold_left = 300;
            end else begin
               hold_left = ((tokens_seen / 10) % 3 == 1) ? 0 : int'($urandom_range(0, 16));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("source_code_tokenizer_core_tb failed");
         $finish;
      end
   end

   initial begin
      int pieces;
      mode = M_IDLE; held = 0; word = 0; offset = 0; tok_start = 0;
      line = 1; col = 1; tok_line = 1; tok_col = 1;
      ival = 0; fdig = 0; fcnt = 0; ended = 0;

      // directed: keywords, pairs, lone bar, hex, dot after digits, high byte
      add_text("fn x=0xFf;a<=b&&c!=d->|");
      add_byte(8'hFF);
      add_text("7.x 2.5\"\\\"");
      add_byte(8'h80);
      add_text("\"");
      add_text("//c\n/**/");

      // long numbers and words: wrap at 64 bits and saturating fraction count
      add_text(" 0x"); add_digits(20, 1);
      add_byte(" "); add_digits(25, 0);
      add_text(" 1."); add_digits(260, 0);
      add_text(" abcdefghij return returns ");

      pieces = 0;
      while (pieces < 8) begin
         add_piece();
         pieces++;
         if (pieces == 4) add_byte(" ", 0, 1);
      end

      // how the text ends
      case ($urandom_range(0, 3))
         0: add_byte("a", 1);
         1: add_byte(8'd0, 1'($urandom_range(0, 1)));
         2: begin add_text("\"ab"); add_byte("\\", 1); end
         default: begin add_text("/* ab"); add_byte("*", 1); end
      endcase
      // bytes after the end are dropped
      add_text("x;1");
      add_byte(8'hA5, 1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (!(all_sent && expected_tokens.size() == 0)) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_tokens.size() == 0)
         $display("source_code_tokenizer_core_tb passed");
      else
         $display("source_code_tokenizer_core_tb failed");
      $finish;
   end

endmodule
